### design/fsp_pkg.sv
// Shared types and constants for the format-spec parser.
// Holds the character class record, the result record and the codes used by
// the front, back and result queue. No dependencies.
package fsp_pkg;

  localparam int MAX_LENGTH  = 65535;
  localparam int NUMBER_BITS = 32;

  localparam int OFFSET_W = 16;
  localparam int VALUE_W  = 32;

  // classified-item queue between front and back
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  // result queue, takes up to two results per cycle
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_INDEX  = 2'd1,
    KIND_VALID  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_ACC          = 4'd0,
    PH_NAME_FIRST   = 4'd1,
    PH_NAME_REST    = 4'd2,
    PH_IDX_FIRST    = 4'd3,
    PH_IDX_REST     = 4'd4,
    PH_CONV         = 4'd5,
    PH_AFTER_CONV   = 4'd6,
    PH_SPEC_START   = 4'd7,
    PH_SIGN         = 4'd8,
    PH_ALT          = 4'd9,
    PH_WIDTH        = 4'd10,
    PH_WIDTH_DIGITS = 4'd11,
    PH_GROUP        = 4'd12,
    PH_TYPE         = 4'd13,
    PH_DONE         = 4'd14
  } phase_t;

  localparam logic [2:0] ALIGN_NONE   = 3'd0;
  localparam logic [2:0] ALIGN_LEFT   = 3'd1;
  localparam logic [2:0] ALIGN_RIGHT  = 3'd2;
  localparam logic [2:0] ALIGN_CENTER = 3'd3;
  localparam logic [2:0] ALIGN_NUMBER = 3'd4;

  localparam logic [1:0] CONV_NONE = 2'd0;
  localparam logic [1:0] CONV_STR  = 2'd1;
  localparam logic [1:0] CONV_REPR = 2'd2;

  localparam logic [1:0] SIGN_MINUS = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  localparam logic [1:0] GROUP_NONE  = 2'd0;
  localparam logic [1:0] GROUP_COMMA = 2'd1;
  localparam logic [1:0] GROUP_UNDER = 2'd2;

  localparam logic [2:0] TYPE_STRING = 3'd0;
  localparam logic [2:0] TYPE_BINARY = 3'd1;
  localparam logic [2:0] TYPE_CHAR   = 3'd2;
  localparam logic [2:0] TYPE_DEC    = 3'd3;
  localparam logic [2:0] TYPE_OCT    = 3'd4;
  localparam logic [2:0] TYPE_HEX_LO = 3'd5;
  localparam logic [2:0] TYPE_HEX_UP = 3'd6;
  localparam logic [2:0] TYPE_LOCALE = 3'd7;

  typedef struct packed {
    logic [1:0] conversion;
    logic       fill_present;
    logic [7:0] fill_char;
    logic [2:0] align;
    logic [1:0] sign;
    logic       alternate;
    logic [1:0] grouping;
    logic [2:0] type_code;
  } spec_t;

  // one input item with its character already classified
  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       last;
    logic       digit;
    logic [3:0] dval;
    logic       ident;
    logic [2:0] align;      // ALIGN_NONE when not an align mark
    logic       tvalid;
    logic [2:0] tcode;
    logic       sign_mark;
    logic [1:0] sign;
    logic       hash;
    logic [1:0] grp;        // GROUP_NONE when not a grouping mark
    logic       dot;
    logic       lbrack;
    logic       rbrack;
    logic       bang;
    logic       colon;
    logic [1:0] conv;       // CONV_NONE when neither s nor r
    logic       printable;
  } cls_t;

  typedef struct packed {
    logic  valid;
    cls_t  cls;
  } fq_head_t;

  typedef struct packed {
    kind_t                kind;
    logic [OFFSET_W-1:0]  position;
    logic [VALUE_W-1:0]   value;
    spec_t                spec;
    logic                 end_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] count;  // 0, 1 or 2 results this cycle
    res_t       r0;
    res_t       r1;
  } rq_push_t;

endpackage

### design/format_spec_parser.sv
// Top level of the format-spec parser: front classifier, parser back end and
// result queue. Depends on fsp_pkg, fsp_front, fsp_back and fsp_resq.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   input    | push / full         | has_char, ch, last
//   result   | pop / empty         | kind, position, value, conversion,
//            |                     | fill_present, fill_char, align, sign,
//            |                     | alternate, grouping, type_code, end_of_run
//
// One request per cycle is taken while the four-entry front queue has space.
// The parser back end retires one character per cycle, limited by the result
// queue: it needs two free slots, and the result port drains one per cycle,
// so a string's last request (accessor plus final result) may have to wait.
// A result passes through the front queue and then the result queue before
// it shows on the result ports.
// Synchronous reset empties both queues and puts the parser at accessor start.
// Either side may stall on its own; the queues absorb the difference.
module format_spec_parser import fsp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                has_char,
  input  logic [7:0]          ch,
  input  logic                last,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          kind,
  output logic [OFFSET_W-1:0] position,
  output logic [VALUE_W-1:0]  value,
  output logic [1:0]          conversion,
  output logic                fill_present,
  output logic [7:0]          fill_char,
  output logic [2:0]          align,
  output logic [1:0]          sign,
  output logic                alternate,
  output logic [1:0]          grouping,
  output logic [2:0]          type_code,
  output logic                end_of_run
);

  fq_head_t fq_head;   // oldest classified request
  logic     fq_deq;    // back end takes it
  logic     rq_room;   // result queue can take two more
  rq_push_t rq_in;     // results of the request taken this cycle
  res_t     rq_head;   // oldest waiting result

  // Front: classify each character as it arrives, queue it
  fsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .has_char (has_char),
    .ch       (ch),
    .last     (last),
    .deq      (fq_deq),
    .full     (full),
    .head     (fq_head)
  );

  // Back: grammar state machine, accessor and final results
  fsp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (fq_head),
    .room  (rq_room),
    .deq   (fq_deq),
    .rq_in (rq_in)
  );

  // Results wait here until the consumer pops them
  fsp_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .rq_in (rq_in),
    .pop   (pop),
    .empty (empty),
    .room  (rq_room),
    .head  (rq_head)
  );

  assign kind         = rq_head.kind;
  assign position     = rq_head.position;
  assign value        = rq_head.value;
  assign conversion   = rq_head.spec.conversion;
  assign fill_present = rq_head.spec.fill_present;
  assign fill_char    = rq_head.spec.fill_char;
  assign align        = rq_head.spec.align;
  assign sign         = rq_head.spec.sign;
  assign alternate    = rq_head.spec.alternate;
  assign grouping     = rq_head.spec.grouping;
  assign type_code    = rq_head.spec.type_code;
  assign end_of_run   = rq_head.end_of_run;

endmodule

### design/fsp_front.sv
// Front part: accepts input items, classifies the character and queues them.
// Depends on fsp_pkg.
module fsp_front import fsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  logic     has_char,
  input  logic [7:0] ch,
  input  logic     last,
  input  logic     deq,
  output logic     full,
  output fq_head_t head
);

  cls_t             q [FQ_DEPTH];
  logic [FQ_PW-1:0] wr_ptr;
  logic [FQ_PW-1:0] rd_ptr;
  logic [FQ_CW-1:0] count;
  logic [FQ_CW-1:0] count_next;
  cls_t             cls_in;
  logic [7:0]       dsub;
  logic             accept;
  logic             take;

  always_comb begin
    dsub             = ch - CH_ZERO;
    cls_in           = '0;
    cls_in.has_char  = has_char;
    cls_in.ch        = ch;
    cls_in.last      = last;
    cls_in.digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);
    cls_in.dval      = dsub[3:0];
    cls_in.ident     = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) || (ch == CH_UNDER);
    cls_in.printable = (ch >= CH_SPACE) && (ch <= CH_TILDE);
    cls_in.hash      = (ch == CH_HASH);
    cls_in.dot       = (ch == CH_DOT);
    cls_in.lbrack    = (ch == CH_LBRACK);
    cls_in.rbrack    = (ch == CH_RBRACK);
    cls_in.bang      = (ch == CH_BANG);
    cls_in.colon     = (ch == CH_COLON);
    unique case (ch)
      CH_LT:    cls_in.align = ALIGN_LEFT;
      CH_GT:    cls_in.align = ALIGN_RIGHT;
      CH_CARET: cls_in.align = ALIGN_CENTER;
      CH_EQ:    cls_in.align = ALIGN_NUMBER;
      default:  cls_in.align = ALIGN_NONE;
    endcase
    unique case (ch)
      CH_PLUS:  begin cls_in.sign_mark = 1'b1; cls_in.sign = SIGN_PLUS;  end
      CH_SPACE: begin cls_in.sign_mark = 1'b1; cls_in.sign = SIGN_SPACE; end
      CH_MINUS: begin cls_in.sign_mark = 1'b1; cls_in.sign = SIGN_MINUS; end
      default:  begin cls_in.sign_mark = 1'b0; cls_in.sign = SIGN_MINUS; end
    endcase
    unique case (ch)
      CH_COMMA: cls_in.grp = GROUP_COMMA;
      CH_UNDER: cls_in.grp = GROUP_UNDER;
      default:  cls_in.grp = GROUP_NONE;
    endcase
    unique case (ch)
      8'h73:   cls_in.conv = CONV_STR;   // s
      8'h72:   cls_in.conv = CONV_REPR;  // r
      default: cls_in.conv = CONV_NONE;
    endcase
    cls_in.tvalid = 1'b1;
    unique case (ch)
      8'h73:   cls_in.tcode = TYPE_STRING;  // s
      8'h62:   cls_in.tcode = TYPE_BINARY;  // b
      8'h63:   cls_in.tcode = TYPE_CHAR;    // c
      8'h64:   cls_in.tcode = TYPE_DEC;     // d
      8'h6F:   cls_in.tcode = TYPE_OCT;     // o
      8'h78:   cls_in.tcode = TYPE_HEX_LO;  // x
      8'h58:   cls_in.tcode = TYPE_HEX_UP;  // X
      8'h6E:   cls_in.tcode = TYPE_LOCALE;  // n
      default: begin
        cls_in.tcode  = TYPE_STRING;
        cls_in.tvalid = 1'b0;
      end
    endcase
  end

  assign full       = (count == FQ_CW'(FQ_DEPTH));
  assign accept     = push && !full;
  assign head.valid = (count != '0);
  assign head.cls   = q[rd_ptr];
  assign take       = deq && head.valid;

  always_comb begin
    count_next = count;
    if (accept && !take) begin
      count_next = count + FQ_CW'(1);
    end else if (!accept && take) begin
      count_next = count - FQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (accept) begin
        wr_ptr <= wr_ptr + FQ_PW'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + FQ_PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cls_in;
    end
  end

endmodule

### design/fsp_back.sv
// Back part: the parser state machine, one classified item per cycle while the
// result queue has room, giving up to two results per item. Depends on fsp_pkg.
module fsp_back import fsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fq_head_t head,
  input  logic     room,
  output logic     deq,
  output rq_push_t rq_in
);

  typedef struct packed {
    phase_t       phase;
    logic [31:0]  accum;
    logic         err;
    spec_t        spec;
  } pst_t;

  localparam logic [35:0] NUM_LIMIT = (36'd1 << NUMBER_BITS) - 36'd1;

  pst_t                st;
  pst_t                st_next;
  logic [OFFSET_W-1:0] offset;
  logic [OFFSET_W-1:0] offset_next;
  logic [OFFSET_W-1:0] ident_start;
  logic [OFFSET_W-1:0] ident_start_next;
  cls_t                held;
  cls_t                held_next;
  logic                held_valid;
  logic                held_valid_next;

  // acc * 10 + d, with the overflow flag on top
  function automatic logic [32:0] mac10(logic [31:0] acc, logic [3:0] d);
    logic [35:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'b0, d};
    return {(v > NUM_LIMIT), v[31:0]};
  endfunction

  // sign, '#', width, grouping, type: each part optional, in that order
  function automatic pst_t spec_stage(pst_t s, cls_t c);
    pst_t        r;
    logic        done;
    logic [32:0] m;
    r    = s;
    done = 1'b0;
    m    = mac10(s.accum, c.dval);
    if (r.phase == PH_SIGN) begin
      r.phase = PH_ALT;
      if (c.sign_mark) begin
        r.spec.sign = c.sign;
        done        = 1'b1;
      end
    end
    if (!done && r.phase == PH_ALT) begin
      r.phase = PH_WIDTH;
      if (c.hash) begin
        r.spec.alternate = 1'b1;
        done             = 1'b1;
      end
    end
    if (!done && r.phase == PH_WIDTH) begin
      if (c.digit) begin
        r.accum = {28'b0, c.dval};
        r.phase = PH_WIDTH_DIGITS;
        done    = 1'b1;
      end else begin
        r.phase = PH_GROUP;
      end
    end
    if (!done && r.phase == PH_WIDTH_DIGITS) begin
      if (c.digit) begin
        if (m[32]) begin
          r.err = 1'b1;
        end else begin
          r.accum = m[31:0];
        end
        done = 1'b1;
      end else begin
        r.phase = PH_GROUP;
      end
    end
    if (!done && r.phase == PH_GROUP) begin
      r.phase = PH_TYPE;
      if (c.grp != GROUP_NONE) begin
        r.spec.grouping = c.grp;
        done            = 1'b1;
      end
    end
    if (!done && r.phase == PH_TYPE && c.tvalid) begin
      r.spec.type_code = c.tcode;
      r.phase          = PH_DONE;
      done             = 1'b1;
    end
    if (!done) begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  // held first char after ':' turned out not to be a fill
  function automatic pst_t take_first(pst_t s, cls_t h);
    pst_t r;
    r       = s;
    r.phase = PH_SIGN;
    if (h.align != ALIGN_NONE) begin
      r.spec.align = h.align;
    end else begin
      r = spec_stage(r, h);
    end
    return r;
  endfunction

  function automatic pst_t acc_char(pst_t s, cls_t c);
    pst_t r;
    r = s;
    if (c.dot) begin
      r.phase = PH_NAME_FIRST;
    end else if (c.lbrack) begin
      r.accum = '0;
      r.phase = PH_IDX_FIRST;
    end else if (c.bang) begin
      r.phase = PH_CONV;
    end else if (c.colon) begin
      r.accum = '0;
      r.phase = PH_SPEC_START;
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  function automatic res_t mk_res(kind_t k, logic [OFFSET_W-1:0] p, logic [VALUE_W-1:0] v,
                                 spec_t sp);
    res_t r;
    r.kind       = k;
    r.position   = p;
    r.value      = v;
    r.spec       = sp;
    r.end_of_run = 1'b0;
    return r;
  endfunction

  cls_t        c;
  pst_t        s;
  logic [32:0] m_idx;
  logic        acc_v;
  logic        fin_v;
  res_t        acc_res;
  res_t        fin_res;
  logic [VALUE_W-1:0] width;

  assign deq = head.valid && room;
  assign c   = head.cls;

  always_comb begin
    s                = st;
    offset_next      = offset;
    ident_start_next = ident_start;
    held_next        = held;
    held_valid_next  = held_valid;
    acc_v            = 1'b0;
    fin_v            = 1'b0;
    acc_res          = mk_res(KIND_NAME, '0, '0, '0);
    fin_res          = mk_res(KIND_REJECT, '0, '0, '0);
    width            = '0;
    m_idx            = mac10(st.accum, c.dval);

    if (c.has_char && !s.err) begin
      if (offset >= OFFSET_W'(MAX_LENGTH)) begin
        s.err = 1'b1;
      end else begin
        unique case (s.phase)
          PH_ACC: begin
            s = acc_char(s, c);
            if (c.colon) held_valid_next = 1'b0;
          end
          PH_NAME_FIRST: begin
            if (c.ident) begin
              ident_start_next = offset;
              s.phase          = PH_NAME_REST;
            end else begin
              s.err = 1'b1;
            end
          end
          PH_NAME_REST: begin
            if (!c.ident) begin
              acc_v   = 1'b1;
              acc_res = mk_res(KIND_NAME, ident_start,
                               VALUE_W'(offset - ident_start), '0);
              s.phase = PH_ACC;
              s       = acc_char(s, c);
              if (c.colon) held_valid_next = 1'b0;
            end
          end
          PH_IDX_FIRST: begin
            if (c.digit) begin
              s.accum = {28'b0, c.dval};
              s.phase = PH_IDX_REST;
            end else begin
              s.err = 1'b1;
            end
          end
          PH_IDX_REST: begin
            if (c.digit) begin
              if (m_idx[32]) s.err = 1'b1;
              else s.accum = m_idx[31:0];
            end else if (c.rbrack) begin
              acc_v   = 1'b1;
              acc_res = mk_res(KIND_INDEX, '0, s.accum, '0);
              s.accum = '0;
              s.phase = PH_ACC;
            end else begin
              s.err = 1'b1;
            end
          end
          PH_CONV: begin
            if (c.conv != CONV_NONE) begin
              s.spec.conversion = c.conv;
              s.phase           = PH_AFTER_CONV;
            end else begin
              s.err = 1'b1;
            end
          end
          PH_AFTER_CONV: begin
            if (c.colon) begin
              s.accum         = '0;
              held_valid_next = 1'b0;
              s.phase         = PH_SPEC_START;
            end else begin
              s.err = 1'b1;
            end
          end
          PH_SPEC_START: begin
            if (!held_valid) begin
              held_next       = c;
              held_valid_next = 1'b1;
            end else begin
              held_valid_next = 1'b0;
              if (c.align != ALIGN_NONE) begin
                // held char is a fill
                if (!held.printable) begin
                  s.err = 1'b1;
                end else begin
                  s.spec.fill_present = 1'b1;
                  s.spec.fill_char    = held.ch;
                  s.spec.align        = c.align;
                  s.phase             = PH_SIGN;
                end
              end else begin
                s = take_first(s, held);
                if (!s.err) s = spec_stage(s, c);
              end
            end
          end
          default: s = spec_stage(s, c);
        endcase
        offset_next = offset + OFFSET_W'(1);
      end
    end

    if (c.last) begin
      unique case (s.phase)
        PH_NAME_REST: begin
          if (!s.err) begin
            acc_v   = 1'b1;
            acc_res = mk_res(KIND_NAME, ident_start_next,
                             VALUE_W'(offset_next - ident_start_next), '0);
          end
        end
        PH_NAME_FIRST, PH_IDX_FIRST, PH_IDX_REST, PH_CONV: s.err = 1'b1;
        PH_SPEC_START: begin
          if (held_valid_next && !s.err) begin
            held_valid_next = 1'b0;
            s               = take_first(s, held_next);
          end
        end
        default: ;
      endcase
      fin_v = 1'b1;
      if (s.err) begin
        fin_res = mk_res(KIND_REJECT, '0, '0, '0);
      end else begin
        width   = (s.phase >= PH_SIGN) ? s.accum : '0;
        fin_res = mk_res(KIND_VALID, '0, width, s.spec);
      end
      // back to the start state for the next string
      s.phase          = PH_ACC;
      s.accum          = '0;
      s.err            = 1'b0;
      s.spec           = '0;
      offset_next      = '0;
      ident_start_next = '0;
      held_valid_next  = 1'b0;
    end

    if (fin_v) fin_res.end_of_run = 1'b1;
    else       acc_res.end_of_run = 1'b1;

    st_next        = s;
    rq_in.count    = deq ? ({1'b0, acc_v} + {1'b0, fin_v}) : 2'd0;
    rq_in.r0       = acc_v ? acc_res : fin_res;
    rq_in.r1       = fin_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase    <= PH_ACC;
      st.accum    <= '0;
      st.err      <= 1'b0;
      st.spec     <= '0;
      offset      <= '0;
      ident_start <= '0;
      held_valid  <= 1'b0;
    end else if (deq) begin
      st          <= st_next;
      offset      <= offset_next;
      ident_start <= ident_start_next;
      held_valid  <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (deq) begin
      held <= held_next;
    end
  end

endmodule

### design/fsp_resq.sv
// Result queue: takes up to two results a cycle, gives one a cycle on pop.
// Depends on fsp_pkg.
module fsp_resq import fsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rq_push_t rq_in,
  input  logic     pop,
  output logic     empty,
  output logic     room,
  output res_t     head
);

  res_t             q [RQ_DEPTH];
  logic [RQ_PW-1:0] wr_ptr;
  logic [RQ_PW-1:0] wr_ptr1;
  logic [RQ_PW-1:0] rd_ptr;
  logic [RQ_CW-1:0] count;
  logic             deq;

  assign empty   = (count == '0);
  assign room    = (count <= RQ_CW'(RQ_DEPTH - 2));
  assign head    = q[rd_ptr];
  assign deq     = pop && !empty;
  assign wr_ptr1 = wr_ptr + RQ_PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PW'(rq_in.count);
      count  <= count + RQ_CW'(rq_in.count) - RQ_CW'(deq);
      if (deq) begin
        rd_ptr <= rd_ptr + RQ_PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_in.count != 2'd0) begin
      q[wr_ptr] <= rq_in.r0;
    end
    if (rq_in.count == 2'd2) begin
      q[wr_ptr1] <= rq_in.r1;
    end
  end

endmodule

### design/fsp_checker.sv
// Port-level checks for the format-spec parser, bound to the top level.
// Depends on fsp_pkg and format_spec_parser.
module fsp_checker import fsp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                pop,
  input logic                empty,
  input logic [1:0]          kind,
  input logic [OFFSET_W-1:0] position,
  input logic [VALUE_W-1:0]  value,
  input logic [1:0]          conversion,
  input logic                fill_present,
  input logic [7:0]          fill_char,
  input logic [2:0]          align,
  input logic [1:0]          sign,
  input logic                alternate,
  input logic [1:0]          grouping,
  input logic [2:0]          type_code,
  input logic                end_of_run
);

  // reset leaves both queues empty
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a final result always closes its string's run
  a_final_ends_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_VALID || kind == KIND_REJECT)) |-> end_of_run)
    else $error("final result without end_of_run");

  // rejected strings carry no spec
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_REJECT) |->
      (value == '0 && position == '0 && align == '0 && fill_present == 1'b0 &&
       fill_char == '0 && sign == '0 && alternate == 1'b0 && grouping == '0 &&
       conversion == '0 && type_code == '0))
    else $error("rejected result with nonzero fields");

  // a waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(value) &&
                          $stable(end_of_run)))
    else $error("waiting result changed");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (.*);

### sim/fsp_scoreboard_pkg.sv
// Scoreboard for the format-spec parser: a bit-exact predictor of the result
// stream and the queue of results still owed by the block.
// Depends on fsp_pkg for the result record, phase codes and character codes.
package fsp_scoreboard_pkg;
  import fsp_pkg::*;

  class spec_scoreboard;
    // parser state, mirrored from the block
    phase_t      ph;
    int unsigned offset;
    logic [31:0] accum;
    int unsigned ident_start;
    logic [7:0]  held_char;
    bit          held_valid;
    spec_t       spec;
    bit          err;

    res_t step_results[$];
    res_t expected_results[$];
    int   errors;

    function new();
      clear_string();
      errors = 0;
    endfunction

    function void clear_string();
      ph          = PH_ACC;
      offset      = 0;
      accum       = '0;
      ident_start = 0;
      held_char   = '0;
      held_valid  = 1'b0;
      spec        = '0;
      err         = 1'b0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void add_result(kind_t k, logic [15:0] pos, logic [31:0] val, bit with_spec);
      res_t r;
      r          = '0;
      r.kind     = k;
      r.position = pos;
      r.value    = val;
      if (with_spec) r.spec = spec;
      step_results.push_back(r);
    endfunction

    function bit dec_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_ident(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDER;
    endfunction

    function logic [2:0] align_of(logic [7:0] c);
      case (c)
        CH_LT:    return ALIGN_LEFT;
        CH_GT:    return ALIGN_RIGHT;
        CH_CARET: return ALIGN_CENTER;
        CH_EQ:    return ALIGN_NUMBER;
        default:  return ALIGN_NONE;
      endcase
    endfunction

    // decimal accumulate; overflow past 32 bits rejects the string
    function void accumulate(logic [7:0] c);
      logic [63:0] v;
      v = 64'(accum) * 64'd10 + 64'(c - CH_ZERO);
      if (v > 64'hFFFF_FFFF) err = 1'b1;
      else accum = v[31:0];
    endfunction

    // the part of the spec after fill/align, stages falling through in order
    function void spec_stage(logic [7:0] c);
      logic [2:0] t;
      bit         t_ok;
      t    = TYPE_STRING;
      t_ok = 1'b1;
      if (ph == PH_SIGN) begin
        if (c == CH_PLUS || c == CH_MINUS || c == CH_SPACE) begin
          spec.sign = (c == CH_PLUS) ? SIGN_PLUS : (c == CH_SPACE) ? SIGN_SPACE : SIGN_MINUS;
          ph = PH_ALT;
          return;
        end
        ph = PH_ALT;
      end
      if (ph == PH_ALT) begin
        ph = PH_WIDTH;
        if (c == CH_HASH) begin
          spec.alternate = 1'b1;
          return;
        end
      end
      if (ph == PH_WIDTH) begin
        if (dec_digit(c)) begin
          accum = 32'(c - CH_ZERO);
          ph    = PH_WIDTH_DIGITS;
          return;
        end
        ph = PH_GROUP;
      end
      if (ph == PH_WIDTH_DIGITS) begin
        if (dec_digit(c)) begin
          accumulate(c);
          return;
        end
        ph = PH_GROUP;
      end
      if (ph == PH_GROUP) begin
        ph = PH_TYPE;
        if (c == CH_COMMA || c == CH_UNDER) begin
          spec.grouping = (c == CH_COMMA) ? GROUP_COMMA : GROUP_UNDER;
          return;
        end
      end
      if (ph == PH_TYPE) begin
        case (c)
          "s":     t = TYPE_STRING;
          "b":     t = TYPE_BINARY;
          "c":     t = TYPE_CHAR;
          "d":     t = TYPE_DEC;
          "o":     t = TYPE_OCT;
          "x":     t = TYPE_HEX_LO;
          "X":     t = TYPE_HEX_UP;
          "n":     t = TYPE_LOCALE;
          default: t_ok = 1'b0;
        endcase
        if (t_ok) begin
          spec.type_code = t;
          ph = PH_DONE;
          return;
        end
      end
      err = 1'b1;
    endfunction

    function void take_first(logic [7:0] h);
      logic [2:0] a;
      a  = align_of(h);
      ph = PH_SIGN;
      if (a != ALIGN_NONE) spec.align = a;
      else spec_stage(h);
    endfunction

    function void enter_spec();
      accum      = '0;
      held_valid = 1'b0;
      ph         = PH_SPEC_START;
    endfunction

    function void accessor_byte(logic [7:0] c);
      if (c == CH_DOT) ph = PH_NAME_FIRST;
      else if (c == CH_LBRACK) begin
        accum = '0;
        ph    = PH_IDX_FIRST;
      end else if (c == CH_BANG) ph = PH_CONV;
      else if (c == CH_COLON) enter_spec();
      else err = 1'b1;
    endfunction

    function void parse_byte(logic [7:0] c);
      logic [2:0] a;
      case (ph)
        PH_ACC: accessor_byte(c);
        PH_NAME_FIRST: begin
          if (is_ident(c)) begin
            ident_start = offset;
            ph = PH_NAME_REST;
          end else err = 1'b1;
        end
        PH_NAME_REST: begin
          if (!is_ident(c)) begin
            add_result(KIND_NAME, 16'(ident_start), offset - ident_start, 1'b0);
            ph = PH_ACC;
            accessor_byte(c);
          end
        end
        PH_IDX_FIRST: begin
          if (dec_digit(c)) begin
            accum = 32'(c - CH_ZERO);
            ph    = PH_IDX_REST;
          end else err = 1'b1;
        end
        PH_IDX_REST: begin
          if (dec_digit(c)) accumulate(c);
          else if (c == CH_RBRACK) begin
            add_result(KIND_INDEX, 16'd0, accum, 1'b0);
            accum = '0;
            ph    = PH_ACC;
          end else err = 1'b1;
        end
        PH_CONV: begin
          if (c == "s" || c == "r") begin
            spec.conversion = (c == "s") ? CONV_STR : CONV_REPR;
            ph = PH_AFTER_CONV;
          end else err = 1'b1;
        end
        PH_AFTER_CONV: begin
          if (c == CH_COLON) enter_spec();
          else err = 1'b1;
        end
        PH_SPEC_START: begin
          // first byte after the colon waits for the next one
          if (!held_valid) begin
            held_char  = c;
            held_valid = 1'b1;
          end else begin
            held_valid = 1'b0;
            a = align_of(c);
            if (a != ALIGN_NONE) begin
              if (held_char < CH_SPACE || held_char > CH_TILDE) err = 1'b1;
              else begin
                spec.fill_present = 1'b1;
                spec.fill_char    = held_char;
                spec.align        = a;
                ph = PH_SIGN;
              end
            end else begin
              take_first(held_char);
              if (!err) spec_stage(c);
            end
          end
        end
        default: spec_stage(c);
      endcase
    endfunction

    function void close_string();
      case (ph)
        PH_NAME_REST:
          if (!err) add_result(KIND_NAME, 16'(ident_start), offset - ident_start, 1'b0);
        PH_NAME_FIRST, PH_IDX_FIRST, PH_IDX_REST, PH_CONV: err = 1'b1;
        PH_SPEC_START: begin
          if (held_valid && !err) begin
            held_valid = 1'b0;
            take_first(held_char);
          end
        end
        default: ;
      endcase
      if (err) add_result(KIND_REJECT, 16'd0, 32'd0, 1'b0);
      else add_result(KIND_VALID, 16'd0, (ph >= PH_SIGN) ? accum : 32'd0, 1'b1);
      clear_string();
    endfunction

    // one accepted request: advance the parser and queue what it owes
    function void note_request(bit hc, logic [7:0] c, bit is_last);
      step_results.delete();
      if (hc && !err) begin
        if (offset >= MAX_LENGTH) err = 1'b1;
        else begin
          parse_byte(c);
          offset++;
        end
      end
      if (is_last) close_string();
      if (step_results.size() > 0) step_results[step_results.size() - 1].end_of_run = 1'b1;
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH: %s", msg);
    endtask

    task compare_field(string name, longint unsigned got, longint unsigned exp);
      if (got != exp)
        report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
    endtask

    task check_result(res_t got);
      res_t exp;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d value %0d with none expected",
                                  got.kind, got.value));
        return;
      end
      exp = expected_results.pop_front();
      compare_field("kind", got.kind, exp.kind);
      compare_field("position", got.position, exp.position);
      compare_field("value", got.value, exp.value);
      compare_field("conversion", got.spec.conversion, exp.spec.conversion);
      compare_field("fill_present", got.spec.fill_present, exp.spec.fill_present);
      compare_field("fill_char", got.spec.fill_char, exp.spec.fill_char);
      compare_field("align", got.spec.align, exp.spec.align);
      compare_field("sign", got.spec.sign, exp.spec.sign);
      compare_field("alternate", got.spec.alternate, exp.spec.alternate);
      compare_field("grouping", got.spec.grouping, exp.spec.grouping);
      compare_field("type_code", got.spec.type_code, exp.spec.type_code);
      compare_field("end_of_run", got.end_of_run, exp.end_of_run);
    endtask
  endclass

endpackage

### sim/format_spec_parser_tb.sv
// Testbench top for format_spec_parser: directed and random format-spec
// strings, checked result by result against the spec_scoreboard predictor.
// Depends on fsp_pkg, fsp_scoreboard_pkg and the format_spec_parser RTL.
module format_spec_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fsp_pkg::*;
  import fsp_scoreboard_pkg::*;

  // cycles with no request or result taken before the run is called hung;
  // the longest legal quiet stretch is the receiver hold-off below
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 450;

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  logic clk;
  logic rst      = 1'b1;
  logic push     = 1'b0;
  logic has_char = 1'b0;
  logic [7:0] ch = 8'h00;
  logic last     = 1'b0;
  logic pop      = 1'b0;
  logic full, empty;
  logic [1:0]          kind;
  logic [OFFSET_W-1:0] position;
  logic [VALUE_W-1:0]  value;
  logic [1:0]          conversion;
  logic                fill_present;
  logic [7:0]          fill_char;
  logic [2:0]          align;
  logic [1:0]          sign;
  logic                alternate;
  logic [1:0]          grouping;
  logic [2:0]          type_code;
  logic                end_of_run;

  spec_scoreboard sb;
  char_req_t      spec_chars[$];   // requests of the string being sent
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  bit             hold_off_req   = 1'b0;
  int             idle_cycles    = 0;

  format_spec_parser u_dut (
    .clk, .rst, .push, .full, .has_char, .ch, .last, .pop, .empty,
    .kind, .position, .value, .conversion, .fill_present, .fill_char,
    .align, .sign, .alternate, .grouping, .type_code, .end_of_run
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: both handshakes sampled at the edge where they complete.
  // Inputs are driven by NBA, so these reads see the pre-edge values.
  always @(posedge clk) begin : monitor
    res_t got;
    if (!rst) begin
      if (push && !full) sb.note_request(has_char, ch, last);
      if (pop && !empty) begin
        got                   = '0;
        got.kind              = kind_t'(kind);
        got.position          = position;
        got.value             = value;
        got.spec.conversion   = conversion;
        got.spec.fill_present = fill_present;
        got.spec.fill_char    = fill_char;
        got.spec.align        = align;
        got.spec.sign         = sign;
        got.spec.alternate    = alternate;
        got.spec.grouping     = grouping;
        got.spec.type_code    = type_code;
        got.end_of_run        = end_of_run;
        sb.check_result(got);
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Watchdog on forward progress.
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls at the phase rate; on a hold-off request it
  // keeps pop low for HOLD_CYCLES, counted here, so the block backs up.
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          pop <= 1'b0;
          @(posedge clk);
        end
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  // One request: optional idle cycles, then hold it until full is low at an edge.
  task automatic send_item(input logic hc, input logic [7:0] c, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    has_char <= hc;
    ch       <= c;
    last     <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_spec();
    foreach (spec_chars[i])
      send_item(spec_chars[i].has_char, spec_chars[i].ch, spec_chars[i].last);
  endtask

  // Directed string; empty_end closes it with a has_char=0 last request.
  task automatic send_text(input string s, input bit empty_end);
    spec_chars.delete();
    for (int i = 0; i < s.len(); i++) spec_chars.push_back('{1'b1, s[i], 1'b0});
    if (empty_end || s.len() == 0) spec_chars.push_back('{1'b0, 8'h00, 1'b1});
    else spec_chars[spec_chars.size() - 1].last = 1'b1;
    send_spec();
  endtask

  // Sender pause: nothing offered until every owed result is back.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(26);
    return (r == 26) ? CH_UNDER : CH_LOWER_A + 8'(r);
  endfunction

  // random byte of the string, now and then preceded by an empty request
  function automatic void put_byte(logic [7:0] c);
    if ($urandom_range(15) == 0) spec_chars.push_back('{1'b0, 8'($urandom), 1'b0});
    spec_chars.push_back('{1'b1, c, 1'b0});
  endfunction

  // mostly short numbers; sometimes 9..11 digits to reach the 32-bit limit
  function automatic void put_digits();
    int n;
    n = ($urandom_range(19) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 3);
    repeat (n) put_byte(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic logic [7:0] align_char();
    case ($urandom_range(3))
      0:       return CH_LT;
      1:       return CH_GT;
      2:       return CH_CARET;
      default: return CH_EQ;
    endcase
  endfunction

  // Random string: mostly well-formed with random content, some broken
  // (overwritten byte or cut short), some plain byte noise.
  function automatic void build_random_spec();
    int mode;
    int i;
    string types;
    string signs;
    types = "sbcdoxXn";
    signs = "+- ";
    spec_chars.delete();
    mode = $urandom_range(99);
    if (mode < 12) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(1)) begin
          put_byte(CH_DOT);
          repeat ($urandom_range(1, 6)) put_byte(ident_char());
        end else begin
          put_byte(CH_LBRACK);
          put_digits();
          put_byte(CH_RBRACK);
        end
      end
      if ($urandom_range(3) == 0) begin
        put_byte(CH_BANG);
        put_byte($urandom_range(1) ? "s" : "r");
      end
      if ($urandom_range(2) != 0) begin
        put_byte(CH_COLON);
        case ($urandom_range(5))
          1: put_byte(align_char());
          2: begin
            put_byte(CH_SPACE + 8'($urandom_range(94)));   // printable fill
            put_byte(align_char());
          end
          3: begin
            put_byte(8'($urandom));                        // any fill byte
            put_byte(align_char());
          end
          default: ;
        endcase
        if ($urandom_range(1)) put_byte(signs[$urandom_range(2)]);
        if ($urandom_range(2) == 0) put_byte(CH_HASH);
        if ($urandom_range(1)) put_digits();
        if ($urandom_range(2) == 0) put_byte($urandom_range(1) ? CH_COMMA : CH_UNDER);
        if ($urandom_range(2) != 0) put_byte(types[$urandom_range(7)]);
      end
      if (mode < 28 && spec_chars.size() > 0) begin
        if ($urandom_range(1)) begin
          i = $urandom_range(spec_chars.size() - 1);
          spec_chars[i].has_char = 1'b1;
          spec_chars[i].ch       = 8'($urandom);
        end else begin
          repeat ($urandom_range(1, 3)) if (spec_chars.size() > 1) void'(spec_chars.pop_back());
        end
      end
    end
    if (spec_chars.size() == 0 || $urandom_range(7) == 0)
      spec_chars.push_back('{1'b0, 8'($urandom), 1'b1});
    else
      spec_chars[spec_chars.size() - 1].last = 1'b1;
  endfunction

  initial begin : stimulus
    int phase_items;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed: accessors, limits, conversions, every align/sign/type ---
    send_text("", 1'b1);                 // empty string, all defaults
    send_text(".ab_c[12].z", 1'b0);      // name, index, name at the end
    send_text(".q", 1'b1);               // identifier closed by an empty last
    send_text("[0]", 1'b0);
    send_text("[4294967295]", 1'b0);     // largest index
    send_text("[4294967296]", 1'b0);     // index overflow
    send_text("[12", 1'b0);              // unfinished index
    send_text(".", 1'b0);                // unfinished name
    send_text("!", 1'b0);                // unfinished conversion
    send_text("!x", 1'b0);
    send_text("x.a", 1'b0);              // bad accessor start
    send_text("!s", 1'b0);
    send_text("!r:", 1'b0);              // colon with nothing after
    send_text(":*<+#10,d", 1'b0);        // full spec with fill
    send_text(":\001<", 1'b0);           // control byte as fill
    send_text(":\177^", 1'b0);           // DEL as fill
    send_text(": =-#0_X", 1'b0);         // space fill, number align
    send_text(":~>4294967295n", 1'b0);   // tilde fill, widest width
    send_text(":4294967296", 1'b0);      // width overflow
    send_text(":<", 1'b0);               // lone align, decided at the end
    send_text(":>5o", 1'b0);             // align without fill, then width
    send_text(":^ b", 1'b0);
    send_text(": c", 1'b1);              // held space becomes the sign
    send_text(":x", 1'b0);               // held byte is the type
    send_text(":<<s", 1'b0);             // align mark used as fill
    send_text(":z", 1'b0);               // held byte fits nothing
    send_text(":dd", 1'b0);              // trailing byte after the type
    send_text("[7]!r:=", 1'b1);
    drain_results();

    // --- random phases: no idling, slow sender, slow receiver, both ---
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // receiver goes quiet while the sender keeps pushing at full rate
      if (p == 0) hold_off_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_random_spec();
        phase_items += spec_chars.size();
        send_spec();
      end
      drain_results();
    end

    // a few more cycles to catch any stray result
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
design/fsp_pkg.sv
design/fsp_front.sv
design/fsp_back.sv
design/fsp_resq.sv
design/format_spec_parser.sv
design/fsp_checker.sv
sim/fsp_scoreboard_pkg.sv
sim/format_spec_parser_tb.sv
